>>> design/bilp_pkg.sv
// Shared types and constants for the BED interval line parser.
`timescale 1ns / 1ps
`default_nettype none
package bilp_pkg;
  localparam int unsigned MaxLineBytes = 100000;
  localparam int unsigned MaxFields = 9;
  localparam int unsigned CoordBits = 40;
  localparam int unsigned PosW = 17;
  localparam int unsigned FldW = 4;
  localparam int unsigned CntW = 20;
  localparam int unsigned AccW = CoordBits + 1;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;

  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChNl = 8'h0a;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_LONG = 3'd1, ST_FIELDS = 3'd2, ST_BAD = 3'd3,
    ST_RANGE = 3'd4, ST_NEG = 3'd5, ST_ORDER = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_SPACE = 3'd0, PH_SIGN = 3'd1, PH_DIGITS = 3'd2, PH_TAIL = 3'd3, PH_BAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CL_DATA = 2'd0, CL_TAB = 2'd1, CL_NEWLINE = 2'd2
  } cls_e;

  // classified word passed from front to back
  typedef struct packed {
    logic [7:0] data;
    cls_e       cls;
    logic       last;
    logic       digit;
    logic       space;
    logic       sign;
  } word_t;
endpackage
`default_nettype wire

>>> design/bilp_front.sv
// Front end: accepts bytes, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module bilp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_content_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output bilp_pkg::word_t    q_word_o
);
  bilp_pkg::word_t mem_q [bilp_pkg::QDepth];
  logic [bilp_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [bilp_pkg::QPtrW:0]   cnt_q;
  bilp_pkg::word_t w;
  logic push, pop;

  always_comb begin
    w.data = data_byte_i;
    w.last = end_of_content_i;
    w.digit = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
    w.space = (data_byte_i == 8'h20) || (data_byte_i == 8'h0b) ||
              (data_byte_i == 8'h0c) || (data_byte_i == 8'h0d);
    w.sign = (data_byte_i == bilp_pkg::ChPlus) || (data_byte_i == bilp_pkg::ChMinus);
    if (data_byte_i == bilp_pkg::ChNl) w.cls = bilp_pkg::CL_NEWLINE;
    else if (data_byte_i == bilp_pkg::ChTab) w.cls = bilp_pkg::CL_TAB;
    else w.cls = bilp_pkg::CL_DATA;
  end

  assign in_ready = (cnt_q != (bilp_pkg::QPtrW+1)'(bilp_pkg::QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign push = in_valid && in_ready;
  assign pop = q_valid_o && q_ready_i;
  assign q_word_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (bilp_pkg::QPtrW+1)'(bilp_pkg::QDepth)) else $error("queue overfill");
  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push not counted");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

>>> design/bilp_back.sv
// Back end: per-line field tracking, number parsing and record output.
`timescale 1ns / 1ps
`default_nettype none
module bilp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [3:0]    expected_fields_i,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  bilp_pkg::word_t    q_word_i,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         status_o,
  output logic [19:0]        line_index_o,
  output logic [39:0]        interval_start_o,
  output logic [39:0]        interval_end_o,
  output logic signed [1:0]  strand_o,
  output logic [16:0]        chrom_offset_o,
  output logic [16:0]        chrom_length_o,
  output logic               has_name_o,
  output logic [16:0]        name_offset_o,
  output logic [16:0]        name_length_o,
  output logic [3:0]         fields_seen_o
);
  localparam int unsigned AW = bilp_pkg::AccW;
  localparam logic [AW-1:0] Lim = AW'(1) << bilp_pkg::CoordBits;
  localparam logic [AW-1:0] Cmax = Lim - AW'(1);

  logic [16:0] pos_q, pos_d;
  logic [3:0]  fld_q, fld_d;
  logic        in_q, in_d, com_q, com_d, neg_q, neg_d;
  bilp_pkg::phase_e ph_q, ph_d;
  logic [AW-1:0] sa_q, sa_d, ea_q, ea_d;
  logic [2:0]  pe_q, pe_d;
  logic signed [1:0] str_q, str_d;
  logic [16:0] co_q, co_d, cl_q, cl_d, no_q, no_d, nl_q, nl_d;
  logic [19:0] lc_q, lc_d;
  logic        ov_q;
  logic [2:0]  os_q;
  logic [19:0] oi_q;
  logic [39:0] ost_q, oen_q;
  logic signed [1:0] ostr_q;
  logic [16:0] oco_q, ocl_q, ono_q, onl_q;
  logic        ohn_q;
  logic [3:0]  ofs_q;

  logic take, emit;
  bilp_pkg::word_t w;
  logic [3:0] cur;
  logic [AW-1:0] acc, acc_n;
  logic [AW+3:0] prod;
  logic [3:0] dv;
  logic [2:0] st;
  logic fin;

  assign w = q_word_i;
  assign q_ready_o = !ov_q || out_ready;
  assign take = q_valid_i && q_ready_o;

  // finish_number on a closed field (pre-feed state on tab, post-feed at EOL)
  function automatic logic [2:0] fin_code(bilp_pkg::phase_e ph, logic ng, logic [AW-1:0] a);
    logic [2:0] c;
    if (ph == bilp_pkg::PH_DIGITS)
      c = (a > Cmax) ? bilp_pkg::ST_RANGE : ((ng && a != '0) ? bilp_pkg::ST_NEG : bilp_pkg::ST_OK);
    else if (ph == bilp_pkg::PH_TAIL)
      c = (a > Cmax) ? bilp_pkg::ST_RANGE : bilp_pkg::ST_BAD;
    else c = bilp_pkg::ST_BAD;
    return c;
  endfunction

  function automatic logic [2:0] merge(logic [2:0] pe, logic [2:0] c);
    logic [2:0] r;
    r = pe;
    if ((c == bilp_pkg::ST_BAD || c == bilp_pkg::ST_RANGE) &&
        (pe == bilp_pkg::ST_OK || pe == bilp_pkg::ST_NEG)) r = c;
    else if (c == bilp_pkg::ST_NEG && pe == bilp_pkg::ST_OK) r = bilp_pkg::ST_NEG;
    return r;
  endfunction

  always_comb begin
    pos_d = pos_q; fld_d = fld_q; in_d = in_q; com_d = com_q; neg_d = neg_q;
    ph_d = ph_q; sa_d = sa_q; ea_d = ea_q; pe_d = pe_q; str_d = str_q;
    co_d = co_q; cl_d = cl_q; no_d = no_q; nl_d = nl_q; lc_d = lc_q;
    cur = '0; acc = '0; acc_n = '0; prod = '0; dv = w.data[3:0]; fin = 1'b0;
    emit = 1'b0; st = bilp_pkg::ST_OK;
    if (w.cls != bilp_pkg::CL_NEWLINE) begin
      if (pos_q <= 17'(bilp_pkg::MaxLineBytes)) pos_d = pos_q + 1'b1;
      if (pos_q == '0 && w.data == bilp_pkg::ChHash) com_d = 1'b1;
      if (!com_d) begin
        if (w.cls == bilp_pkg::CL_TAB) begin
          fin = in_q;
          in_d = 1'b0;
        end else if (in_q || fld_q < 4'(bilp_pkg::MaxFields)) begin
          if (!in_q) begin
            cur = fld_q;
            fld_d = fld_q + 1'b1;
            in_d = 1'b1;
            if (cur == 4'd0) begin co_d = pos_q; cl_d = '0; end
            if (cur == 4'd3) begin no_d = pos_q; nl_d = '0; end
            if (cur == 4'd5)
              str_d = (w.data == bilp_pkg::ChPlus) ? 2'sd1 :
                      ((w.data == bilp_pkg::ChMinus) ? -2'sd1 : 2'sd0);
            if (cur == 4'd1 || cur == 4'd2) begin ph_d = bilp_pkg::PH_SPACE; neg_d = 1'b0; end
          end
          cur = fld_d - 1'b1;
          if (cur == 4'd0) cl_d = cl_d + 1'b1;
          else if (cur == 4'd3) nl_d = nl_d + 1'b1;
          else if (cur == 4'd1 || cur == 4'd2) begin
            acc = (cur == 4'd1) ? sa_q : ea_q;
            acc_n = acc;
            case (ph_d)
              bilp_pkg::PH_SPACE: begin
                if (w.space) ;
                else if (w.sign) begin
                  ph_d = bilp_pkg::PH_SIGN; neg_d = (w.data == bilp_pkg::ChMinus);
                end else if (!w.digit) ph_d = bilp_pkg::PH_BAD;
                else ph_d = bilp_pkg::PH_DIGITS;
              end
              bilp_pkg::PH_SIGN:
                ph_d = w.digit ? bilp_pkg::PH_DIGITS : bilp_pkg::PH_BAD;
              bilp_pkg::PH_DIGITS:
                if (!w.digit) ph_d = bilp_pkg::PH_TAIL;
              bilp_pkg::PH_TAIL: ;
              default: ph_d = bilp_pkg::PH_BAD;
            endcase
            if (w.digit && ph_d == bilp_pkg::PH_DIGITS) begin
              // saturate once ten times the value plus the digit passes the limit
              prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (AW+4)'(dv);
              if (acc >= Lim || prod > (AW+4)'(Lim)) acc_n = Lim;
              else acc_n = prod[AW-1:0];
            end
            if (cur == 4'd1) sa_d = acc_n; else ea_d = acc_n;
          end
        end
      end
    end
    if (fin) begin
      if (fld_q == 4'd2) pe_d = merge(pe_q, fin_code(ph_q, neg_q, sa_q));
      else if (fld_q == 4'd3) pe_d = merge(pe_q, fin_code(ph_q, neg_q, ea_q));
    end
    if (w.cls == bilp_pkg::CL_NEWLINE || w.last) begin
      if (pos_d != '0) begin
        lc_d = lc_q + 1'b1;
        if (!com_d) begin
          emit = 1'b1;
          if (in_d) begin
            if (fld_d == 4'd2) pe_d = merge(pe_d, fin_code(ph_d, neg_d, sa_d));
            else if (fld_d == 4'd3) pe_d = merge(pe_d, fin_code(ph_d, neg_d, ea_d));
          end
          if (pos_d > 17'(bilp_pkg::MaxLineBytes)) st = bilp_pkg::ST_LONG;
          else if (expected_fields_i < 4'd3 || expected_fields_i > 4'(bilp_pkg::MaxFields) ||
                   fld_d != expected_fields_i) st = bilp_pkg::ST_FIELDS;
          else if (pe_d != '0) st = pe_d;
          else st = (sa_d >= ea_d) ? bilp_pkg::ST_ORDER : bilp_pkg::ST_OK;
        end
      end
    end
  end

  wire logic ok_full = (st == bilp_pkg::ST_OK) || (st >= bilp_pkg::ST_RANGE);
  wire logic eol = (w.cls == bilp_pkg::CL_NEWLINE) || w.last;

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      os_q <= st;
      oi_q <= lc_q;
      ofs_q <= (st == bilp_pkg::ST_LONG) ? 4'd0 : fld_d;
      ost_q <= ok_full ? ((sa_d > Cmax) ? Cmax[39:0] : sa_d[39:0]) : '0;
      oen_q <= ok_full ? ((ea_d > Cmax) ? Cmax[39:0] : ea_d[39:0]) : '0;
      ostr_q <= ok_full ? str_d : 2'sd0;
      oco_q <= ok_full ? co_d : '0;
      ocl_q <= ok_full ? cl_d : '0;
      ohn_q <= ok_full && (fld_d >= 4'd4);
      ono_q <= (ok_full && fld_d >= 4'd4) ? no_d : '0;
      onl_q <= (ok_full && fld_d >= 4'd4) ? nl_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; fld_q <= '0; in_q <= 1'b0; com_q <= 1'b0; neg_q <= 1'b0;
      ph_q <= bilp_pkg::PH_SPACE; sa_q <= '0; ea_q <= '0; pe_q <= '0;
      str_q <= '0; co_q <= '0; cl_q <= '0; no_q <= '0; nl_q <= '0; lc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (out_ready) ov_q <= 1'b0;
      if (take) begin
        if (emit) ov_q <= 1'b1;
        lc_q <= lc_d;
        if (eol) begin
          pos_q <= '0; fld_q <= '0; in_q <= 1'b0; com_q <= 1'b0; neg_q <= 1'b0;
          ph_q <= bilp_pkg::PH_SPACE; sa_q <= '0; ea_q <= '0; pe_q <= '0;
          str_q <= '0; co_q <= '0; cl_q <= '0; no_q <= '0; nl_q <= '0;
        end else begin
          pos_q <= pos_d; fld_q <= fld_d; in_q <= in_d; com_q <= com_d; neg_q <= neg_d;
          ph_q <= ph_d; sa_q <= sa_d; ea_q <= ea_d; pe_q <= pe_d; str_q <= str_d;
          co_q <= co_d; cl_q <= cl_d; no_q <= no_d; nl_q <= nl_d;
        end
      end
    end
  end

  assign out_valid = ov_q;
  assign status_o = os_q;
  assign line_index_o = oi_q;
  assign interval_start_o = ost_q;
  assign interval_end_o = oen_q;
  assign strand_o = ostr_q;
  assign chrom_offset_o = oco_q;
  assign chrom_length_o = ocl_q;
  assign has_name_o = ohn_q;
  assign name_offset_o = ono_q;
  assign name_length_o = onl_q;
  assign fields_seen_o = ofs_q;

  a_fld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_q <= 4'(bilp_pkg::MaxFields)) else $error("field count overrun");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready) |-> !take) else $error("took word while output blocked");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 17'(bilp_pkg::MaxLineBytes + 1)) else $error("line position overrun");
endmodule
`default_nettype wire

>>> design/bed_interval_line_parser.sv
// Top level of the BED interval line parser.
// A line's ending byte is queued; the back end takes it and registers out_valid.
// Throughput: one byte per cycle unless the queue is full; the back end processes
// one queued word each cycle unless its output is stalled. A four-entry queue
// between front and back absorbs output stalls. Reset (rst_ni low, asynchronous)
// clears line state, line counter and queue; expected_fields returns to 3.
`timescale 1ns / 1ps
`default_nettype none
module bed_interval_line_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   expected_fields_i,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         end_of_content_i,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        status_o,
  output logic [19:0]       line_index_o,
  output logic [39:0]       interval_start_o,
  output logic [39:0]       interval_end_o,
  output logic signed [1:0] strand_o,
  output logic [16:0]       chrom_offset_o,
  output logic [16:0]       chrom_length_o,
  output logic              has_name_o,
  output logic [16:0]       name_offset_o,
  output logic [16:0]       name_length_o,
  output logic [3:0]        fields_seen_o
);
  logic [3:0] exp_q;
  logic q_valid, q_ready;
  bilp_pkg::word_t q_word;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) exp_q <= 4'd3;
    else if (cfg_valid) exp_q <= expected_fields_i;
  end

  bilp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .data_byte_i, .end_of_content_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_word_o(q_word)
  );

  bilp_back u_back (
    .clk_i, .rst_ni, .expected_fields_i(exp_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_word_i(q_word),
    .out_valid, .out_ready, .status_o, .line_index_o, .interval_start_o,
    .interval_end_o, .strand_o, .chrom_offset_o, .chrom_length_o, .has_name_o,
    .name_offset_o, .name_length_o, .fields_seen_o
  );
endmodule
`default_nettype wire
